### rtl/smbrw_pkg.sv
`default_nettype none

package smbrw_pkg;

  localparam int unsigned ADDR_W = 7;

  localparam logic [ADDR_W-1:0] DEV_ADDR_RESET = 7'h5A;
  localparam logic [7:0] STATUS_MASK      = 8'hF8;
  localparam logic [7:0] ST_ADDR_W_ACK    = 8'h18;
  localparam logic [7:0] ST_CMD_ACK       = 8'h28;
  localparam logic [7:0] ST_ADDR_R_ACK    = 8'h40;
  localparam logic [7:0] CRC_POLY         = 8'h07;

  typedef enum logic [0:0] {
    FUNC_BEGIN = 1'b0,
    FUNC_DONE  = 1'b1
  } func_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_START1 = 4'd1,
    PH_ADDR_W = 4'd2,
    PH_CMD    = 4'd3,
    PH_START2 = 4'd4,
    PH_ADDR_R = 4'd5,
    PH_LOW    = 4'd6,
    PH_HIGH   = 4'd7,
    PH_PEC    = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_START     = 3'd1,
    ACT_WRITE     = 3'd2,
    ACT_READ_ACK  = 3'd3,
    ACT_READ_NACK = 3'd4,
    ACT_STOP      = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_ADDR_W   = 3'd1,
    ERR_CMD      = 3'd2,
    ERR_ADDR_R   = 3'd3,
    ERR_PEC      = 3'd4
  } err_t;

  typedef struct packed {
    logic [0:0] func;
    logic [7:0] command_code;
    logic [7:0] status_code;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  bus_action;
    logic [7:0]  tx_byte;
    logic [0:0]  done_res;
    logic [2:0]  error_code;
    logic [15:0] word_value;
  } out_word_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] crc;
    logic [7:0] command;
    logic [7:0] low_data;
    logic [7:0] high_data;
  } seq_state_t;

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/smbrw_step.sv
`default_nettype none

module smbrw_step
  import smbrw_pkg::*;
(
  input  seq_state_t        st,
  input  in_word_t          item,
  input  logic [ADDR_W-1:0] dev_addr,
  output seq_state_t        st_nxt,
  output out_word_t         res
);

  logic [7:0] addr_w;
  logic [7:0] addr_r;
  logic [7:0] status;
  logic [7:0] crc_in;
  logic       crc_upd;

  assign addr_w  = {dev_addr, 1'b0};
  assign addr_r  = {dev_addr, 1'b1};
  assign status  = item.status_code & STATUS_MASK;

  always_comb begin
    st_nxt  = st;
    res     = '0;
    crc_in  = item.rx_byte;
    crc_upd = 1'b0;
    if (item.func == FUNC_BEGIN) begin
      st_nxt.command = item.command_code;
      st_nxt.crc     = '0;
      st_nxt.phase   = PH_START1;
      res.bus_action = ACT_START;
    end else begin
      case (st.phase)
        PH_START1: begin
          res.bus_action = ACT_WRITE;
          res.tx_byte    = addr_w;
          crc_in         = addr_w;
          crc_upd        = 1'b1;
          st_nxt.phase   = PH_ADDR_W;
        end
        PH_ADDR_W: begin
          if (status != ST_ADDR_W_ACK) begin
            res.done_res   = 1'b1;
            res.error_code = ERR_ADDR_W;
            st_nxt.phase   = PH_IDLE;
          end else begin
            res.bus_action = ACT_WRITE;
            res.tx_byte    = st.command;
            crc_in         = st.command;
            crc_upd        = 1'b1;
            st_nxt.phase   = PH_CMD;
          end
        end
        PH_CMD: begin
          if (status != ST_CMD_ACK) begin
            res.done_res   = 1'b1;
            res.error_code = ERR_CMD;
            st_nxt.phase   = PH_IDLE;
          end else begin
            res.bus_action = ACT_START;
            st_nxt.phase   = PH_START2;
          end
        end
        PH_START2: begin
          res.bus_action = ACT_WRITE;
          res.tx_byte    = addr_r;
          crc_in         = addr_r;
          crc_upd        = 1'b1;
          st_nxt.phase   = PH_ADDR_R;
        end
        PH_ADDR_R: begin
          if (status != ST_ADDR_R_ACK) begin
            res.done_res   = 1'b1;
            res.error_code = ERR_ADDR_R;
            st_nxt.phase   = PH_IDLE;
          end else begin
            res.bus_action = ACT_READ_ACK;
            st_nxt.phase   = PH_LOW;
          end
        end
        PH_LOW: begin
          st_nxt.low_data = item.rx_byte;
          crc_upd         = 1'b1;
          res.bus_action  = ACT_READ_ACK;
          st_nxt.phase    = PH_HIGH;
        end
        PH_HIGH: begin
          st_nxt.high_data = item.rx_byte;
          crc_upd          = 1'b1;
          res.bus_action   = ACT_READ_NACK;
          st_nxt.phase     = PH_PEC;
        end
        PH_PEC: begin
          res.bus_action = ACT_STOP;
          res.done_res   = 1'b1;
          if (st.crc != item.rx_byte) begin
            res.error_code = ERR_PEC;
          end else begin
            res.word_value = {st.high_data, st.low_data};
          end
          st_nxt.phase = PH_IDLE;
        end
        default: begin
          // completion while idle (or a stray code): nothing to do
          st_nxt.phase = PH_IDLE;
        end
      endcase
      if (crc_upd) begin
        st_nxt.crc = crc8_byte(st.crc, crc_in);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/smbus_read_word_pec_sequencer.sv
`default_nettype none

// SMBus read-word master sequencer with PEC check. Send a begin word
// (func 0, command code) and then one completion word (func 1, masked bus
// status, received byte) after each bus phase; every input word yields one
// result word naming the next bus action, and the last one carries done,
// the error code and the little-endian data word. Throughput is one word
// per clock when not stalled; a word passes through the input register
// and the result register, with the sequencer step and a byte-wide CRC-8
// update between them. out_ready low stalls both stages. The target address
// is written on the cfg port, which is always ready, and must only change
// while no transaction word is in flight.
module smbus_read_word_pec_sequencer
  import smbrw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ADDR_W-1:0] cfg_data
);

  logic              s1_valid_r;
  in_word_t          s1_data_r;
  logic              out_valid_r;
  out_word_t         out_data_r;
  logic [ADDR_W-1:0] dev_addr_r;
  seq_state_t        st_r;
  seq_state_t        st_nxt;
  out_word_t         res_nxt;
  logic              adv;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || adv;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  smbrw_step u_step (
    .st       (st_r),
    .item     (s1_data_r),
    .dev_addr (dev_addr_r),
    .st_nxt   (st_nxt),
    .res      (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      dev_addr_r  <= DEV_ADDR_RESET;
      st_r        <= '{phase: PH_IDLE, crc: '0, command: '0, low_data: '0, high_data: '0};
    end else begin
      if (cfg_valid) begin
        dev_addr_r <= cfg_data;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (adv && s1_valid_r) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (adv && s1_valid_r) begin
      out_data_r <= res_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_err_implies_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.error_code != ERR_OK) |-> out_data_r.done_res)
    else $error("error code without done");

  a_ok_done_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.done_res && (out_data_r.error_code == ERR_OK)
    |-> out_data_r.bus_action == ACT_STOP)
    else $error("successful end without stop");

  a_word_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.word_value != '0)
    |-> out_data_r.done_res && (out_data_r.error_code == ERR_OK))
    else $error("data word outside successful end");

  a_done_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_valid_r && res_nxt.done_res |=> st_r.phase == PH_IDLE)
    else $error("sequencer not idle after end of transaction");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(st_r))
    else $error("sequencer state moved during output stall");
`endif

endmodule

`default_nettype wire
